// File: rtl/contiguous_page_allocator_top_defines.svh
// Assertion macros for the contiguous page allocator.
// Included by contiguous_page_allocator_top; expects clk_i and rst_ni in scope.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpa_pkg.sv
// Shared types and constants of the contiguous page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package cpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_PAGES_DEF  = 1024;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_PADDR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MANAGED_PAGES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_PAGES = 2'd2;

  localparam logic [LEN_W-1:0] MANAGED_PAGES_RST = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  typedef struct packed {
    logic              op;
    logic [LEN_W-1:0]  page_count;
    logic [ADDR_W-1:0] release_addr;
  } cpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    logic [1:0]        status;
  } cpa_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic       capture;
    logic       scan;
    logic       walk;
    logic       walk_mark;
    logic       free_len;
    logic       load_out;
    logic [1:0] rsp_status;
  } cpa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic found;
    logic scan_done;
    logic want_zero;
    logic bad_free;
    logic len_zero;
    logic walk_done;
  } cpa_stat_t;

endpackage

// File: rtl/cpa_ctrl.sv
// Sequencing state machine of the contiguous page allocator.
// Drives cpa_pkg::cpa_cmd_t to the datapath and reads cpa_pkg::cpa_stat_t back.
module cpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  cpa_pkg::cpa_stat_t  stat_i,
  output cpa_pkg::cpa_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FCHK,
    S_FLEN,
    S_FWALK,
    S_DONE
  } state_e;

  state_e     state_q;
  logic       out_valid_q;
  logic [1:0] rsp_code_q;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan       = (state_q == S_SCAN);
    cmd_o.walk       = (state_q == S_CLEAR) || (state_q == S_MARK) || (state_q == S_FWALK);
    cmd_o.walk_mark  = (state_q == S_MARK);
    cmd_o.free_len   = (state_q == S_FLEN);
    cmd_o.load_out   = (state_q == S_DONE) && out_free;
    cmd_o.rsp_status = rsp_code_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      rsp_code_q  <= cpa_pkg::ST_OK;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (stat_i.walk_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            rsp_code_q <= cpa_pkg::ST_OK;
            state_q    <= (in_op_i == cpa_pkg::OP_ALLOC) ? S_SCAN : S_FCHK;
          end
        end
        S_SCAN: begin
          if (stat_i.want_zero) begin
            rsp_code_q <= cpa_pkg::ST_NO_SPACE;
            state_q    <= S_DONE;
          end else if (stat_i.found) begin
            state_q <= S_MARK;
          end else if (stat_i.scan_done) begin
            rsp_code_q <= cpa_pkg::ST_NO_SPACE;
            state_q    <= S_DONE;
          end
        end
        S_MARK: begin
          if (stat_i.walk_done) begin
            state_q <= S_DONE;
          end
        end
        S_FCHK: begin
          if (stat_i.bad_free) begin
            rsp_code_q <= cpa_pkg::ST_BAD;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_FLEN;
          end
        end
        S_FLEN: begin
          // A page that does not start a run releases nothing.
          state_q <= stat_i.len_zero ? S_DONE : S_FWALK;
        end
        S_FWALK: begin
          if (stat_i.walk_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/cpa_datapath.sv
// Datapath of the contiguous page allocator: configuration registers, the
// used-bit and run-length memories, scan and walk counters, result register.
// Depends on cpa_pkg.
module cpa_datapath #(
  parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cpa_pkg::CFG_W-1:0]        cfg_data_i,
  input  cpa_pkg::cpa_req_t                in_data_i,
  output cpa_pkg::cpa_rsp_t                out_data_o,
  input  cpa_pkg::cpa_cmd_t                cmd_i,
  output cpa_pkg::cpa_stat_t               stat_o
);

  localparam int AW     = cpa_pkg::ADDR_W;
  localparam int LW     = cpa_pkg::LEN_W;
  localparam int IDX_W  = $clog2(MAX_PAGES);
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int W      = (CNT_W > LW) ? CNT_W : LW;
  localparam int EW     = W + 1;
  localparam int PB_LOG = $clog2(PAGE_BYTES);
  localparam int FREE_W = AW - PB_LOG;
  localparam int CW     = (FREE_W > W) ? FREE_W : W;

  // Configuration.
  logic [AW-1:0] base_q;
  logic [LW-1:0] managed_q;
  logic [LW-1:0] reserved_q;

  // Item and result.
  cpa_pkg::cpa_req_t req_q;
  logic [AW-1:0]     res_addr_q;
  cpa_pkg::cpa_rsp_t out_q;

  // Scan and walk control.
  logic [CNT_W-1:0] scan_idx_q;
  logic             pend_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic [CNT_W-1:0] run_cnt_q;
  logic [IDX_W-1:0] run_start_q;
  logic [IDX_W-1:0] walk_q;
  logic [IDX_W-1:0] walk_last_q;

  // Memories and their registered read data.
  logic          used_mem [MAX_PAGES];
  logic [LW-1:0] rl_mem   [MAX_PAGES];
  logic          used_rd_q;
  logic [LW-1:0] rl_rd_q;

  logic [W-1:0]      lim_w;
  logic [CNT_W-1:0]  lim_c;
  logic              issue_ok;
  logic              page_free;
  logic [CNT_W-1:0]  run_next;
  logic              found;
  logic [IDX_W-1:0]  start_idx;
  logic [AW-1:0]     off;
  logic [FREE_W-1:0] fidx_wide;
  logic [IDX_W-1:0]  free_idx;
  logic [EW-1:0]     end_sum;
  logic [EW-1:0]     end_clip;
  logic [IDX_W-1:0]  free_last;
  logic              walk_done;
  logic              rl_we;
  logic [IDX_W-1:0]  rl_waddr;
  logic [LW-1:0]     rl_wdata;

  // A managed count above the memory depth acts as the depth.
  assign lim_w = (W'(managed_q) > W'(MAX_PAGES)) ? W'(MAX_PAGES) : W'(managed_q);
  assign lim_c = lim_w[CNT_W-1:0];

  assign issue_ok  = (scan_idx_q < lim_c);
  assign page_free = !used_rd_q && (W'(pend_idx_q) >= W'(reserved_q));
  assign run_next  = run_cnt_q + CNT_W'(1);
  assign found     = cmd_i.scan && pend_q && page_free && (W'(run_next) == W'(req_q.page_count));
  assign start_idx = (run_cnt_q == '0) ? pend_idx_q : run_start_q;

  // Free address checks and page index.
  assign off       = req_q.release_addr - base_q;
  assign fidx_wide = off[AW-1:PB_LOG];
  assign free_idx  = fidx_wide[IDX_W-1:0];
  assign end_sum   = EW'(free_idx) + EW'(rl_rd_q);
  assign end_clip  = (end_sum > EW'(lim_c)) ? EW'(lim_c) : end_sum;
  assign free_last = IDX_W'(end_clip - EW'(1));

  assign walk_done = (walk_q == walk_last_q);

  assign rl_we    = (cmd_i.walk && !cmd_i.walk_mark) || found;
  assign rl_waddr = found ? start_idx : walk_q;
  assign rl_wdata = found ? req_q.page_count : '0;

  always_comb begin
    stat_o           = '0;
    stat_o.found     = found;
    stat_o.scan_done = !pend_q && !issue_ok;
    stat_o.want_zero = (req_q.page_count == '0);
    stat_o.bad_free  = (req_q.release_addr < base_q) || (off[PB_LOG-1:0] != '0) ||
                       (CW'(fidx_wide) >= CW'(lim_c));
    stat_o.len_zero  = (rl_rd_q == '0);
    stat_o.walk_done = walk_done;
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      managed_q  <= cpa_pkg::MANAGED_PAGES_RST;
      reserved_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpa_pkg::REG_BASE_PADDR:     base_q     <= cfg_data_i[AW-1:0];
        cpa_pkg::REG_MANAGED_PAGES:  managed_q  <= cfg_data_i[LW-1:0];
        cpa_pkg::REG_RESERVED_PAGES: reserved_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // Reset leaves the walk set up for the clearing pass over every entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      run_cnt_q   <= '0;
      run_start_q <= '0;
      walk_q      <= '0;
      walk_last_q <= IDX_W'(MAX_PAGES - 1);
    end else begin
      if (cmd_i.capture) begin
        scan_idx_q <= '0;
        pend_q     <= 1'b0;
        run_cnt_q  <= '0;
      end
      if (cmd_i.scan) begin
        if (issue_ok) begin
          scan_idx_q <= scan_idx_q + CNT_W'(1);
        end
        pend_q     <= issue_ok;
        pend_idx_q <= scan_idx_q[IDX_W-1:0];
        if (pend_q) begin
          if (page_free) begin
            run_cnt_q <= run_next;
            if (run_cnt_q == '0) begin
              run_start_q <= pend_idx_q;
            end
          end else begin
            run_cnt_q <= '0;
          end
        end
        if (found) begin
          walk_q      <= start_idx;
          walk_last_q <= pend_idx_q;
        end
      end
      if (cmd_i.free_len) begin
        walk_q      <= free_idx;
        walk_last_q <= free_last;
      end
      if (cmd_i.walk && !walk_done) begin
        walk_q <= walk_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q      <= in_data_i;
      res_addr_q <= '0;
    end
    if (found) begin
      res_addr_q <= base_q + (AW'(start_idx) << PB_LOG);
    end
    if (cmd_i.load_out) begin
      out_q.block_addr <= res_addr_q;
      out_q.status     <= cmd_i.rsp_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk) begin
      used_mem[walk_q] <= cmd_i.walk_mark;
    end
    used_rd_q <= used_mem[scan_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    rl_rd_q <= rl_mem[free_idx];
  end

endmodule

// File: rtl/contiguous_page_allocator_top.sv
// First-fit contiguous page allocator over a used-bit map of MAX_PAGES pages of
// PAGE_BYTES each. After reset the block clears its used-bit and run-length
// memories, one entry a cycle, and accepts no item until that pass ends;
// configuration writes are taken at any time. One item is worked on at a time.
// An allocate scans the map from page 0 through a single read port, one page a
// cycle, then marks the found run one page a cycle. A free walks the run,
// clearing one page a cycle. A finished result waits in an output register, so
// the next item is taken while it is still held.
`include "contiguous_page_allocator_top_defines.svh"

module contiguous_page_allocator_top #(
  parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = cpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cpa_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cpa_pkg::cpa_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cpa_pkg::cpa_rsp_t             out_data_o
);

  cpa_pkg::cpa_cmd_t  cmd;
  cpa_pkg::cpa_stat_t stat;

  cpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.op),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

  // No memory walk or scan may run while the block offers to take an item.
  `CPA_ASSERT_IMP(a_idle_quiet, in_ready_o, !cmd.walk && !cmd.scan, "walk or scan while ready")
  // The scan never overlaps a memory walk or a result load.
  `CPA_ASSERT_IMP(a_scan_excl, cmd.scan, !cmd.walk && !cmd.load_out, "scan overlaps other work")
  // Only a successful allocate carries a nonzero address.
  `CPA_ASSERT_IMP(a_fail_addr, out_valid_o && (out_data_o.status != cpa_pkg::ST_OK),
                  out_data_o.block_addr == '0, "failed item carries an address")
  // A loaded result is presented in the next cycle.
  `CPA_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_o, "loaded result not presented")

endmodule
